[rtl/lccf_pkg.sv]
package lccf_pkg;

    localparam int SAMPLE_W    = 11;
    localparam int WEIGHT_W    = 16;
    localparam int STATUS_W    = 2;
    localparam int FACTOR_W    = 24;
    localparam int OFFSET_W    = 32;
    localparam int WINDOW_W    = 4;
    localparam int STEP_W      = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int ADC_TOP      = 1020;
    localparam int SCALE_SHIFT  = 10;
    localparam int SCALE_MASK   = (1 << SCALE_SHIFT) - 1;
    localparam int ROUND_BIAS   = 4;
    localparam int ROUND_STEP   = 10;
    localparam int TENS_TOP     = 32760;
    localparam int FACTOR_RESET = 1024;

    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_OFFSET  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_MINUS1 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIVISION_STEP = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd2;

    typedef struct packed {
        logic insert;
        logic rotate;
    } lccf_cell_ctl_t;

endpackage

[rtl/load_cell_calibrate_filter.sv]
// Load cell calibration and filtering. A sample word enters on the s_ channel
// (s_valid, s_ready, s_adc_sample) and one result word leaves on the m_ channel
// (m_valid, m_ready, m_weight, m_status) for every sample taken.
// Gain, offset, window length and quantization step are written on the cfg_
// port by the user only while no sample is in flight; the block does not check.
// A valid sample is scaled by one multiply, pushed into a row of RING_DEPTH
// cells, and the cells then rotate once around so that the newest entries
// pass the accumulator one per cycle. A bit-serial divider forms the average
// and then the quantization remainder, one quotient bit per cycle each time.
// An out-of-range sample skips the multiply, the ring and the divider: its
// status word is set in ST_IDLE and goes straight to the output register.
// One sample is in work at a time, so a new sample is taken only once the
// last one has been loaded into the output register.
// The result sits in an output register, so the next sample is taken while a
// finished word waits; if the receiver stalls, the block holds its next
// result until the output register frees.
// Reset clears all cells to zero, restores the register defaults and drops
// any word in flight.
module load_cell_calibrate_filter #(
    parameter int RING_DEPTH = 10
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [lccf_pkg::SAMPLE_W-1:0]     s_adc_sample,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [lccf_pkg::WEIGHT_W-1:0]     m_weight,
    output logic        [lccf_pkg::STATUS_W-1:0]     m_status,
    input  logic                                     cfg_wr_en,
    input  logic        [lccf_pkg::CFG_INDEX_W-1:0]  cfg_wr_index,
    input  logic        [lccf_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import lccf_pkg::*;

    localparam int SUM_W   = WEIGHT_W + $clog2(RING_DEPTH);
    localparam int QB_W    = WEIGHT_W + 1;
    localparam int DIV_W   = (SUM_W > QB_W) ? SUM_W : QB_W;
    localparam int CNT_W   = $clog2(RING_DEPTH);
    localparam int CW_MIN  = WINDOW_W + 1;
    localparam int CW      = ($clog2(RING_DEPTH + 1) > CW_MIN) ? $clog2(RING_DEPTH + 1) : CW_MIN;
    localparam int MAG_W   = SAMPLE_W - 1;
    localparam int PROD_W  = FACTOR_W + SAMPLE_W;
    localparam int SSUM_W  = PROD_W + 1;
    localparam int SQ_W    = SSUM_W - SCALE_SHIFT;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_DIV1  = 3'd4;
    localparam logic [2:0] ST_DIV2  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic signed [FACTOR_W-1:0] factor_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic        [WINDOW_W-1:0] window_reg;
    logic        [STEP_W-1:0]   step_reg;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg;
    logic       out_load;

    logic        [MAG_W-1:0]    sample_reg, sample_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [SUM_W-1:0]    acc_reg, acc_next;
    logic        [CNT_W-1:0]    rot_cnt_reg, rot_cnt_next;
    logic signed [QB_W-1:0]     qbase_reg, qbase_next;
    logic signed [WEIGHT_W-1:0] res_weight_reg, res_weight_next;
    logic        [STATUS_W-1:0] res_status_reg, res_status_next;
    logic signed [WEIGHT_W-1:0] m_weight_reg;
    logic        [STATUS_W-1:0] m_status_reg;

    logic signed [SSUM_W-1:0]   scale_sum, scale_adj;
    logic signed [SQ_W-1:0]     scale_q;
    logic                       scale_fits;
    logic signed [WEIGHT_W-1:0] scaled;

    logic [CW-1:0] count_full, count;

    logic signed [WEIGHT_W-1:0] avg;
    logic signed [QB_W-1:0]     quant;

    logic                       div_start;
    logic signed [DIV_W-1:0]    div_dividend;
    logic        [STEP_W-1:0]   div_divisor;
    logic                       div_done;
    logic signed [DIV_W-1:0]    div_quotient;
    logic signed [STEP_W:0]     div_remainder;

    lccf_cell_ctl_t             cell_ctl;
    logic signed [WEIGHT_W-1:0] cell_value [RING_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= FACTOR_W'(FACTOR_RESET);
            offset_reg <= '0;
            window_reg <= '0;
            step_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_SCALE_FACTOR:  factor_reg <= cfg_wr_data[FACTOR_W-1:0];
                REG_SCALE_OFFSET:  offset_reg <= cfg_wr_data[OFFSET_W-1:0];
                REG_WINDOW_MINUS1: window_reg <= cfg_wr_data[WINDOW_W-1:0];
                REG_DIVISION_STEP: step_reg   <= cfg_wr_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        count_full = CW'(window_reg) + CW'(1);
        count      = (count_full > CW'(RING_DEPTH)) ? CW'(RING_DEPTH) : count_full;
    end

    always_comb begin
        scale_sum  = SSUM_W'(prod_reg) + SSUM_W'(offset_reg);
        scale_adj  = scale_sum + (scale_sum[SSUM_W-1] ? SSUM_W'(SCALE_MASK) : SSUM_W'(0));
        scale_q    = $signed(scale_adj[SSUM_W-1:SCALE_SHIFT]);
        scale_fits = (scale_q[SQ_W-1:WEIGHT_W-1] == '0) || (scale_q[SQ_W-1:WEIGHT_W-1] == '1);
        if (scale_fits) begin
            scaled = scale_q[WEIGHT_W-1:0];
        end else if (scale_q[SQ_W-1]) begin
            scaled = {1'b1, {(WEIGHT_W-1){1'b0}}};
        end else begin
            scaled = {1'b0, {(WEIGHT_W-1){1'b1}}};
        end
    end

    assign cell_ctl.insert = (state_reg == ST_SCALE);
    assign cell_ctl.rotate = (state_reg == ST_SUM);

    for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
        logic signed [WEIGHT_W-1:0] prev_value;
        if (i == 0) begin : g_head
            assign prev_value = scaled;
        end else begin : g_body
            assign prev_value = cell_value[i-1];
        end
        lccf_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (cell_ctl),
            .prev_value (prev_value),
            .next_value (cell_value[(i + 1) % RING_DEPTH]),
            .value      (cell_value[i])
        );
    end

    lccf_div #(
        .DIV_W (DIV_W),
        .DSR_W (STEP_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign avg      = div_quotient[WEIGHT_W-1:0];
    assign quant    = qbase_reg - QB_W'(div_remainder);

    always_comb begin
        state_next      = state_reg;
        sample_next     = sample_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        rot_cnt_next    = rot_cnt_reg;
        qbase_next      = qbase_reg;
        res_weight_next = res_weight_reg;
        res_status_next = res_status_reg;
        div_start       = 1'b0;
        div_dividend    = DIV_W'(acc_reg);
        div_divisor     = STEP_W'(count);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = s_adc_sample[MAG_W-1:0];
                    if (s_adc_sample[SAMPLE_W-1]) begin
                        res_weight_next = '0;
                        res_status_next = STATUS_UNDER;
                        state_next      = ST_DONE;
                    end else if (s_adc_sample > SAMPLE_W'(ADC_TOP)) begin
                        res_weight_next = '0;
                        res_status_next = STATUS_OVER;
                        state_next      = ST_DONE;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = factor_reg * $signed({1'b0, sample_reg});
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                acc_next     = '0;
                rot_cnt_next = '0;
                state_next   = ST_SUM;
            end
            ST_SUM: begin
                if (CW'(rot_cnt_reg) < count) begin
                    acc_next = acc_reg + SUM_W'(cell_value[0]);
                end
                rot_cnt_next = rot_cnt_reg + CNT_W'(1);
                if (rot_cnt_reg == CNT_W'(RING_DEPTH - 1)) begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(acc_next);
                    state_next   = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    if (step_reg == '0) begin
                        qbase_next  = QB_W'(avg) + QB_W'(ROUND_BIAS);
                        div_divisor = STEP_W'(ROUND_STEP);
                    end else begin
                        qbase_next  = QB_W'(avg);
                        div_divisor = step_reg;
                    end
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(qbase_next);
                    state_next   = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    if (!quant[QB_W-1] && quant[WEIGHT_W-1]) begin
                        res_weight_next = WEIGHT_W'(TENS_TOP);
                    end else begin
                        res_weight_next = quant[WEIGHT_W-1:0];
                    end
                    res_status_next = STATUS_OK;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rot_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rot_cnt_reg <= rot_cnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg     <= sample_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        qbase_reg      <= qbase_next;
        res_weight_reg <= res_weight_next;
        res_status_reg <= res_status_next;
        if (out_load) begin
            m_weight_reg <= res_weight_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_weight = m_weight_reg;
    assign m_status = m_status_reg;

endmodule

[rtl/lccf_cell.sv]
module lccf_cell (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lccf_pkg::lccf_cell_ctl_t              ctl,
    input  logic signed [lccf_pkg::WEIGHT_W-1:0]  prev_value,
    input  logic signed [lccf_pkg::WEIGHT_W-1:0]  next_value,
    output logic signed [lccf_pkg::WEIGHT_W-1:0]  value
);
    import lccf_pkg::*;

    logic signed [WEIGHT_W-1:0] value_reg;
    logic signed [WEIGHT_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctl.insert) begin
            value_next = prev_value;
        end else if (ctl.rotate) begin
            value_next = next_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

[rtl/lccf_div.sv]
module lccf_div #(
    parameter int DIV_W = 20,
    parameter int DSR_W = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] dividend,
    input  logic        [DSR_W-1:0] divisor,
    output logic                    done,
    output logic signed [DIV_W-1:0] quotient,
    output logic signed [DSR_W:0]   remainder
);
    import lccf_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;

    logic [DSR_W:0]   shifted;
    logic [DSR_W+1:0] diff;
    logic             fits;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dsr_reg};
        fits      = !diff[DSR_W+1];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            neg_next  = dividend[DIV_W-1];
            quo_next  = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign remainder = neg_reg ? -$signed({1'b0, rem_reg}) : $signed({1'b0, rem_reg});

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

    import lccf_pkg::*;

    localparam int RING_DEPTH = 10;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic        [STATUS_W-1:0] status;
    } weight_word_t;

    typedef struct {
        bit                     is_write;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        int                     sample;
        bit                     typed;
        weight_word_t           word;
    } stim_row_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic signed [SAMPLE_W-1:0]        s_adc_sample;
    logic                              m_valid;
    logic                              m_ready;
    logic signed [WEIGHT_W-1:0]        m_weight;
    logic        [STATUS_W-1:0]        m_status;
    logic                              cfg_wr_en;
    logic        [CFG_INDEX_W-1:0]     cfg_wr_index;
    logic        [CFG_DATA_W-1:0]      cfg_wr_data;

    logic signed [FACTOR_W-1:0]        gain_reg;
    logic signed [OFFSET_W-1:0]        offset_reg;
    logic        [WINDOW_W-1:0]        window_reg;
    logic        [STEP_W-1:0]          step_reg;
    logic signed [WEIGHT_W-1:0]        weight_ring [RING_DEPTH];
    int                                ring_slot;

    weight_word_t                      pending_words [$];
    weight_word_t                      oldest_word;
    stim_row_t                         directed_rows [$];
    int                                failures = 0;
    int                                no_gap_run;
    int                                stall_left;
    int                                free_left;
    int                                pick;
    int                                cfg_pick;
    bit                                hold_outputs;
    bit                                hold_done;

    load_cell_calibrate_filter #(
        .RING_DEPTH(RING_DEPTH)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_adc_sample(s_adc_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_weight    (m_weight),
        .m_status    (m_status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("load_cell_calibrate_filter verification failed");
        $finish;
    end

    function automatic weight_word_t predict_weight(input logic signed [SAMPLE_W-1:0] sample);
        weight_word_t word;
        longint       scaled;
        int           s;
        int           sum;
        int           count;
        int           avg;
        int           q;
        int           step_i;
        int           slot;
        s = int'(sample);
        if (s > ADC_TOP || s < 0) begin
            word.weight = '0;
            word.status = (s > ADC_TOP) ? STATUS_OVER : STATUS_UNDER;
            return word;
        end
        scaled = (longint'(gain_reg) * s + longint'(offset_reg)) / 1024;
        if (scaled > 32767) begin
            scaled = 32767;
        end else if (scaled < -32768) begin
            scaled = -32768;
        end
        weight_ring[ring_slot] = scaled[WEIGHT_W-1:0];
        count = int'(window_reg) + 1;
        if (count > RING_DEPTH) begin
            count = RING_DEPTH;
        end
        slot = ring_slot;
        sum = 0;
        for (int k = 0; k < count; k++) begin
            sum += weight_ring[slot];
            slot = (slot == 0) ? RING_DEPTH - 1 : slot - 1;
        end
        ring_slot = (ring_slot + 1 >= RING_DEPTH) ? 0 : ring_slot + 1;
        avg = sum / count;
        step_i = int'(step_reg);
        if (step_i == 0) begin
            q = ((avg + ROUND_BIAS) / ROUND_STEP) * ROUND_STEP;
            if (q > 32767) begin
                q = TENS_TOP;
            end
        end else begin
            q = (avg / step_i) * step_i;
        end
        word.weight = q[WEIGHT_W-1:0];
        word.status = STATUS_OK;
        return word;
    endfunction

    function automatic int sender_gap();
        int r;
        if (no_gap_run > 0) begin
            no_gap_run--;
            return 0;
        end
        r = $urandom_range(0, 19);
        if (r == 0) begin
            no_gap_run = $urandom_range(10, 40);
            return 0;
        end else if (r < 10) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16) begin
            return SAMPLE_W'($urandom_range(0, ADC_TOP));
        end else if (r == 16) begin
            return ($urandom_range(0, 1) == 0) ? SAMPLE_W'(0) : SAMPLE_W'(ADC_TOP);
        end
        return SAMPLE_W'($urandom);
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample, input bit typed,
                               input weight_word_t typed_word);
        weight_word_t predicted;
        int           gap;
        s_valid <= 1'b1;
        s_adc_sample <= sample;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_weight(sample);
        pending_words.push_back(typed ? typed_word : predicted);
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (index)
            REG_SCALE_FACTOR:  gain_reg = data[FACTOR_W-1:0];
            REG_SCALE_OFFSET:  offset_reg = data;
            REG_WINDOW_MINUS1: window_reg = data[WINDOW_W-1:0];
            REG_DIVISION_STEP: step_reg = data[STEP_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_settings(input int gain, input int offset, input int window,
                                  input int step);
        write_reg(REG_SCALE_FACTOR, gain);
        write_reg(REG_SCALE_OFFSET, offset);
        write_reg(REG_WINDOW_MINUS1, window);
        write_reg(REG_DIVISION_STEP, step);
    endtask

    task automatic add_row(input bit is_write, input logic [CFG_INDEX_W-1:0] index,
                           input int data_or_sample, input bit typed, input int weight,
                           input logic [STATUS_W-1:0] status);
        stim_row_t row;
        row.is_write = is_write;
        row.index = index;
        row.data = data_or_sample;
        row.sample = data_or_sample;
        row.typed = typed;
        row.word.weight = WEIGHT_W'(weight);
        row.word.status = status;
        directed_rows.push_back(row);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: weight %0d status %0d", m_weight, m_status);
                failures++;
            end else begin
                oldest_word = pending_words.pop_front();
                if (m_weight !== oldest_word.weight) begin
                    $error("weight: expected %0d, got %0d", oldest_word.weight, m_weight);
                    failures++;
                end
                if (m_status !== oldest_word.status) begin
                    $error("status: expected %0d, got %0d", oldest_word.status, m_status);
                    failures++;
                end
            end
        end
    end

    initial begin
        m_ready <= 1'b0;
        hold_done = 1'b0;
        stall_left = 0;
        free_left = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (hold_outputs && !hold_done) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (free_left > 0) begin
                free_left--;
                m_ready <= 1'b1;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    free_left = $urandom_range(20, 80);
                end else if (pick < 9) begin
                    stall_left = $urandom_range(0, 3);
                end else begin
                    stall_left = $urandom_range(20, 60);
                end
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_adc_sample = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data = '0;
        no_gap_run = 0;
        hold_outputs = 1'b0;
        gain_reg = FACTOR_W'(FACTOR_RESET);
        offset_reg = '0;
        window_reg = '0;
        step_reg = '0;
        ring_slot = 0;
        for (int k = 0; k < RING_DEPTH; k++) begin
            weight_ring[k] = '0;
        end

        add_row(0, '0, 0, 1, 0, STATUS_OK);
        add_row(0, '0, ADC_TOP, 1, ADC_TOP, STATUS_OK);
        add_row(0, '0, ADC_TOP + 1, 1, 0, STATUS_OVER);
        add_row(0, '0, 1023, 1, 0, STATUS_OVER);
        add_row(0, '0, -1, 1, 0, STATUS_UNDER);
        add_row(0, '0, -1024, 1, 0, STATUS_UNDER);
        add_row(0, '0, 6, 1, 10, STATUS_OK);
        add_row(0, '0, 5, 1, 0, STATUS_OK);
        add_row(1, REG_SCALE_FACTOR, 8388607, 0, 0, STATUS_OK);
        add_row(0, '0, ADC_TOP, 1, TENS_TOP, STATUS_OK);
        add_row(0, '0, 1, 0, 0, STATUS_OK);
        add_row(1, REG_SCALE_FACTOR, -8388608, 0, 0, STATUS_OK);
        add_row(0, '0, ADC_TOP, 1, -TENS_TOP, STATUS_OK);
        add_row(0, '0, 0, 1, 0, STATUS_OK);
        add_row(1, REG_SCALE_OFFSET, -2147483648, 0, 0, STATUS_OK);
        add_row(0, '0, 0, 1, -TENS_TOP, STATUS_OK);
        add_row(1, REG_SCALE_OFFSET, 2147483647, 0, 0, STATUS_OK);
        add_row(1, REG_SCALE_FACTOR, FACTOR_RESET, 0, 0, STATUS_OK);
        add_row(0, '0, 0, 1, TENS_TOP, STATUS_OK);
        add_row(1, REG_SCALE_OFFSET, 0, 0, 0, STATUS_OK);
        add_row(1, REG_WINDOW_MINUS1, 15, 0, 0, STATUS_OK);
        add_row(1, REG_DIVISION_STEP, 1023, 0, 0, STATUS_OK);
        add_row(0, '0, ADC_TOP, 0, 0, STATUS_OK);
        add_row(0, '0, 500, 0, 0, STATUS_OK);
        add_row(0, '0, 7, 0, 0, STATUS_OK);
        add_row(0, '0, ADC_TOP + 1, 0, 0, STATUS_OK);
        add_row(0, '0, 0, 0, 0, STATUS_OK);
        add_row(1, REG_DIVISION_STEP, 1, 0, 0, STATUS_OK);
        add_row(0, '0, 333, 0, 0, STATUS_OK);
        add_row(1, REG_WINDOW_MINUS1, 9, 0, 0, STATUS_OK);
        add_row(1, REG_DIVISION_STEP, 1000, 0, 0, STATUS_OK);
        add_row(0, '0, ADC_TOP, 0, 0, STATUS_OK);
        add_row(0, '0, 999, 0, 0, STATUS_OK);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_write) begin
                wait_idle();
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end else begin
                send_sample(SAMPLE_W'(directed_rows[i].sample), directed_rows[i].typed,
                            directed_rows[i].word);
            end
        end

        for (int phase = 0; phase < 10; phase++) begin
            wait_idle();
            case (phase)
                0: apply_settings(FACTOR_RESET, 0, 0, 0);
                1: apply_settings(8388607, 2147483647, 15, 1023);
                2: apply_settings(-8388608, -2147483648, 9, 1);
                3: apply_settings(32, 512, 3, 5);
                default: begin
                    cfg_pick = $urandom_range(0, 9);
                    apply_settings((cfg_pick < 2) ? int'($urandom)
                                                  : $urandom_range(0, 66000) - 33000,
                                   (cfg_pick == 9) ? int'($urandom)
                                                   : (cfg_pick > 6) ? 0
                                                   : $urandom_range(0, 2000000) - 1000000,
                                   $urandom_range(0, 15),
                                   (cfg_pick < 3) ? 0
                                                  : (cfg_pick < 7) ? $urandom_range(1, 50)
                                                  : $urandom_range(0, 1023));
                end
            endcase
            if (phase == 4) begin
                hold_outputs = 1'b1;
            end
            for (int n = 0; n < 75; n++) begin
                if (phase == 6 && n == 35) begin
                    wait_idle();
                end
                send_sample(draw_sample(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (60) @(posedge aclk);
        if (failures == 0) begin
            $display("load_cell_calibrate_filter verification clean");
        end else begin
            $display("load_cell_calibrate_filter verification failed");
        end
        $finish;
    end

endmodule
